// ===== rtl/core/i2c_dac_command_formatter_unit_macros.svh =====
// Assertion macros for the I2C DAC command formatter.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef I2C_DAC_COMMAND_FORMATTER_UNIT_MACROS_SVH
`define I2C_DAC_COMMAND_FORMATTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define I2CDAC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cdac: same-cycle check failed");
// next-cycle implication
`define I2CDAC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cdac: next-cycle check failed");
`else
`define I2CDAC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define I2CDAC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/i2cdac_pkg.sv =====
// Shared types and constants for the I2C DAC command formatter.
// No dependencies; used by i2cdac_div_lane and the top level.
`timescale 1ns / 1ps
`default_nettype none
package i2cdac_pkg;

  // request modes
  localparam logic [2:0] MODE_RAW    = 3'd0;
  localparam logic [2:0] MODE_PCT    = 3'd1;
  localparam logic [2:0] MODE_MV     = 3'd2;
  localparam logic [2:0] MODE_REG    = 3'd3;
  localparam logic [2:0] MODE_REG_EE = 3'd4;
  localparam logic [2:0] MODE_PD     = 3'd5;
  localparam logic [2:0] MODE_PD_EE  = 3'd6;

  // frame lengths
  localparam logic [1:0] FLEN_NONE = 2'd0;
  localparam logic [1:0] FLEN_FAST = 2'd2;
  localparam logic [1:0] FLEN_REG  = 2'd3;

  // register-mode command bytes
  localparam logic [7:0] CMD_WRITE_DAC    = 8'h40;
  localparam logic [7:0] CMD_WRITE_DAC_EE = 8'h60;

  localparam logic [15:0] CODE_MAX     = 16'd4095;
  localparam logic [15:0] PCT_FULL     = 16'd10000;
  localparam logic [15:0] MAX_MV_RESET = 16'd5000;

  // serial divider geometry: numerator < denominator * 2**QUO_W always holds
  localparam int NUM_W     = 28;
  localparam int DEN_W     = 16;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef logic [NUM_W-1:0] numer_t;
  typedef logic [DEN_W-1:0] denom_t;
  typedef logic [QUO_W-1:0] quot_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV1  = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_LOAD2 = 7'b0010000,
    S_DIV2  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/i2c_dac_command_formatter_unit.sv =====
// Each request passes prep, an optional conversion divide, apply and a readback divide;
// percent and millivolt requests that need conversion take two 16-step divides, others one.
// One request at a time; the next is taken once the previous has left the core,
// while its result may still wait in the output register.
// Synchronous reset clears code cache, power-down mode and sets full scale 5000 mV.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_dac_command_formatter_unit_macros.svh"
module i2c_dac_command_formatter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [16:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic             frame_valid,
  output logic [1:0]       frame_len,
  output logic [7:0]       frame_byte0,
  output logic [7:0]       frame_byte1,
  output logic [7:0]       frame_byte2,
  output logic [11:0]      dac_code,
  output logic [13:0]      percent_x100,
  output logic [15:0]      voltage_mv
);

  i2cdac_pkg::state_t state;
  logic [i2cdac_pkg::CNT_W-1:0] cnt;
  logic                         cnt_last;

  logic [15:0] max_mv;
  logic [11:0] last_code;
  logic [1:0]  pd_mode;

  logic [2:0]  mode_r;
  logic [16:0] value_r;
  logic [15:0] cand;
  logic        err;
  logic        conv;
  logic [15:0] code_in;

  // staged result
  logic        st_status;
  logic        st_fvalid;
  logic [1:0]  st_flen;
  logic [7:0]  st_b0;
  logic [7:0]  st_b1;
  logic [7:0]  st_b2;

  // prep decode
  logic        prep_err;
  logic        prep_div;
  logic [15:0] prep_cand;

  // apply decode
  logic        ap_status;
  logic        ap_emit;
  logic        ap_reg;
  logic        ap_pd_we;
  logic [11:0] ap_code;
  logic [1:0]  ap_pd;
  logic [7:0]  ap_cmd;

  i2cdac_pkg::lane_ctrl_t ctrl_a;
  i2cdac_pkg::lane_ctrl_t ctrl_b;
  i2cdac_pkg::numer_t     numer_a;
  i2cdac_pkg::numer_t     numer_b;
  i2cdac_pkg::denom_t     denom_a;
  i2cdac_pkg::quot_t      quot_a;
  i2cdac_pkg::quot_t      quot_b;

  assign in_ready = (state == i2cdac_pkg::S_IDLE);
  assign cnt_last = (cnt == i2cdac_pkg::CNT_W'(i2cdac_pkg::DIV_STEPS - 1));
  // converted code comes straight from lane A
  assign code_in  = conv ? quot_a : cand;

  always_comb begin
    prep_err  = 1'b0;
    prep_div  = 1'b0;
    prep_cand = value_r[15:0];
    unique case (mode_r) inside
      i2cdac_pkg::MODE_RAW: begin
        prep_err = value_r[16];
      end
      i2cdac_pkg::MODE_PCT: begin
        prep_err = value_r[16] || (value_r[15:0] > i2cdac_pkg::PCT_FULL);
        prep_div = !prep_err;
      end
      i2cdac_pkg::MODE_MV: begin
        prep_err = value_r[16];
        if (!value_r[16]) begin
          if (value_r[15:0] >= max_mv) begin
            prep_cand = i2cdac_pkg::CODE_MAX;
          end else begin
            prep_div = 1'b1;
          end
        end
      end
      i2cdac_pkg::MODE_REG, i2cdac_pkg::MODE_REG_EE: begin
        prep_err = value_r[16] || (value_r[15:0] > i2cdac_pkg::CODE_MAX);
      end
      default: begin
      end
    endcase
  end

  // raw, percent and millivolt requests skip a repeat before the range check
  always_comb begin
    ap_status = 1'b0;
    ap_emit   = 1'b0;
    ap_reg    = 1'b0;
    ap_pd_we  = 1'b0;
    ap_code   = code_in[11:0];
    ap_pd     = pd_mode;
    ap_cmd    = i2cdac_pkg::CMD_WRITE_DAC;
    unique case (mode_r) inside
      i2cdac_pkg::MODE_RAW, i2cdac_pkg::MODE_PCT, i2cdac_pkg::MODE_MV: begin
        if (err) begin
          ap_status = 1'b1;
        end else if (code_in == {4'b0, last_code}) begin
          ap_emit = 1'b0;
        end else if (code_in > i2cdac_pkg::CODE_MAX) begin
          ap_status = 1'b1;
        end else begin
          ap_emit = 1'b1;
        end
      end
      i2cdac_pkg::MODE_REG, i2cdac_pkg::MODE_REG_EE: begin
        ap_status = err;
        ap_emit   = !err;
        ap_reg    = 1'b1;
        if (mode_r == i2cdac_pkg::MODE_REG_EE) begin
          ap_cmd = i2cdac_pkg::CMD_WRITE_DAC_EE;
        end
      end
      i2cdac_pkg::MODE_PD, i2cdac_pkg::MODE_PD_EE: begin
        ap_emit  = 1'b1;
        ap_reg   = 1'b1;
        ap_pd_we = 1'b1;
        ap_pd    = value_r[1:0];
        ap_code  = last_code;
        if (mode_r == i2cdac_pkg::MODE_PD_EE) begin
          ap_cmd = i2cdac_pkg::CMD_WRITE_DAC_EE;
        end
      end
      default: begin
      end
    endcase
  end

  // lane A: code conversion, then percentage; lane B: millivolts
  always_comb begin
    ctrl_a.load = ((state == i2cdac_pkg::S_PREP) && prep_div) ||
                  (state == i2cdac_pkg::S_LOAD2);
    ctrl_a.step = (state == i2cdac_pkg::S_DIV1) || (state == i2cdac_pkg::S_DIV2);
    ctrl_b.load = (state == i2cdac_pkg::S_LOAD2);
    ctrl_b.step = (state == i2cdac_pkg::S_DIV2);
    if (state == i2cdac_pkg::S_LOAD2) begin
      numer_a = i2cdac_pkg::NUM_W'(last_code) * i2cdac_pkg::NUM_W'(i2cdac_pkg::PCT_FULL);
      denom_a = i2cdac_pkg::CODE_MAX;
    end else begin
      numer_a = i2cdac_pkg::NUM_W'(value_r[15:0]) * i2cdac_pkg::NUM_W'(i2cdac_pkg::CODE_MAX);
      denom_a = (mode_r == i2cdac_pkg::MODE_PCT) ? i2cdac_pkg::PCT_FULL : max_mv;
    end
    numer_b = i2cdac_pkg::NUM_W'(last_code) * i2cdac_pkg::NUM_W'(max_mv);
  end

  i2cdac_div_lane u_lane_a (
    .clk   (clk),
    .ctrl  (ctrl_a),
    .numer (numer_a),
    .denom (denom_a),
    .quot  (quot_a)
  );

  i2cdac_div_lane u_lane_b (
    .clk   (clk),
    .ctrl  (ctrl_b),
    .numer (numer_b),
    .denom (i2cdac_pkg::CODE_MAX),
    .quot  (quot_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= i2cdac_pkg::S_IDLE;
      cnt       <= '0;
      max_mv    <= i2cdac_pkg::MAX_MV_RESET;
      last_code <= '0;
      pd_mode   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_mv <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != i2cdac_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        i2cdac_pkg::S_IDLE: begin
          if (in_valid) begin
            mode_r  <= mode;
            value_r <= value;
            state   <= i2cdac_pkg::S_PREP;
          end
        end
        i2cdac_pkg::S_PREP: begin
          err  <= prep_err;
          cand <= prep_cand;
          conv <= prep_div;
          cnt  <= '0;
          state <= prep_div ? i2cdac_pkg::S_DIV1 : i2cdac_pkg::S_APPLY;
        end
        i2cdac_pkg::S_DIV1: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= i2cdac_pkg::S_APPLY;
          end
        end
        i2cdac_pkg::S_APPLY: begin
          // after a conversion the quotient sits in lane A
          if (ap_emit) begin
            last_code <= ap_code;
          end
          if (ap_pd_we) begin
            pd_mode <= ap_pd;
          end
          st_status <= ap_status;
          st_fvalid <= ap_emit;
          if (!ap_emit) begin
            st_flen <= i2cdac_pkg::FLEN_NONE;
            st_b0   <= '0;
            st_b1   <= '0;
            st_b2   <= '0;
          end else if (ap_reg) begin
            st_flen <= i2cdac_pkg::FLEN_REG;
            st_b0   <= ap_cmd | {5'b0, ap_pd, 1'b0};
            st_b1   <= ap_code[11:4];
            st_b2   <= {ap_code[3:0], 4'b0};
          end else begin
            st_flen <= i2cdac_pkg::FLEN_FAST;
            st_b0   <= {2'b0, ap_pd, ap_code[11:8]};
            st_b1   <= ap_code[7:0];
            st_b2   <= '0;
          end
          state <= i2cdac_pkg::S_LOAD2;
        end
        i2cdac_pkg::S_LOAD2: begin
          cnt   <= '0;
          state <= i2cdac_pkg::S_DIV2;
        end
        i2cdac_pkg::S_DIV2: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= i2cdac_pkg::S_DONE;
          end
        end
        i2cdac_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= i2cdac_pkg::S_IDLE;
          end
        end
        default: begin
          state <= i2cdac_pkg::S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded as the request leaves the core
  always_ff @(posedge clk) begin
    if ((state == i2cdac_pkg::S_DONE) && (!out_valid || out_ready)) begin
      status       <= st_status;
      frame_valid  <= st_fvalid;
      frame_len    <= st_flen;
      frame_byte0  <= st_b0;
      frame_byte1  <= st_b1;
      frame_byte2  <= st_b2;
      dac_code     <= last_code;
      percent_x100 <= quot_a[13:0];
      voltage_mv   <= quot_b;
    end
  end

  // handshake ready only between requests
  `I2CDAC_ASSERT_NXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)
  // a rejected value never carries a frame
  `I2CDAC_ASSERT_IMP(a_err_no_frame, clk, rst, out_valid && status, !frame_valid && frame_len == i2cdac_pkg::FLEN_NONE)
  // emitted frames are fast or register mode
  `I2CDAC_ASSERT_IMP(a_frame_len, clk, rst, out_valid && frame_valid, frame_len == i2cdac_pkg::FLEN_FAST || frame_len == i2cdac_pkg::FLEN_REG)
  // percentage divide stays within full scale
  `I2CDAC_ASSERT_IMP(a_pct_range, clk, rst, out_valid, percent_x100 <= 14'd10000)

endmodule
`default_nettype wire

// ===== rtl/core/i2cdac_div_lane.sv =====
// Radix-2 restoring divider lane: one quotient bit per step.
// Depends on i2cdac_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none
module i2cdac_div_lane (
  input  wire logic                   clk,
  input  wire i2cdac_pkg::lane_ctrl_t ctrl,
  input  wire i2cdac_pkg::numer_t     numer,
  input  wire i2cdac_pkg::denom_t     denom,
  output i2cdac_pkg::quot_t           quot
);

  logic [i2cdac_pkg::DEN_W-1:0] rem;
  logic [i2cdac_pkg::QUO_W-1:0] sh;
  logic [i2cdac_pkg::DEN_W-1:0] den;
  logic [i2cdac_pkg::DEN_W:0]   trial;
  logic                         qbit;
  logic [i2cdac_pkg::DEN_W:0]   diff;

  always_comb begin
    trial = {rem, sh[i2cdac_pkg::QUO_W-1]};
    qbit  = (trial >= {1'b0, den});
    diff  = trial - {1'b0, den};
  end

  // upper numerator bits seed the remainder, lower bits shift in one a step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= i2cdac_pkg::DEN_W'(numer[i2cdac_pkg::NUM_W-1:i2cdac_pkg::QUO_W]);
      sh  <= numer[i2cdac_pkg::QUO_W-1:0];
      den <= denom;
    end else if (ctrl.step) begin
      rem <= qbit ? diff[i2cdac_pkg::DEN_W-1:0] : trial[i2cdac_pkg::DEN_W-1:0];
      sh  <= {sh[i2cdac_pkg::QUO_W-2:0], qbit};
    end
  end

  assign quot = sh;

endmodule
`default_nettype wire
